// ----- rtl/jddm_pkg.sv -----
// ----------------------------------------------------------------------------
// Joystick drive mixer package
// Field widths, register indexes, reset values and mixing constants shared
// by the differential drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

  // Field widths of the event, result and configuration transactions.
  localparam int AXIS_W      = 8;
  localparam int VALUE_W     = 16;
  localparam int DEAD_ZONE_W = 15;
  localparam int DUTY_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_ZONE  = 2'd0,
    REG_DRIVE_AXIS = 2'd1,
    REG_STEER_AXIS = 2'd2
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [DEAD_ZONE_W-1:0] DEAD_ZONE_RST  = 15'd3276;
  localparam logic [AXIS_W-1:0]      DRIVE_AXIS_RST = 8'd1;
  localparam logic [AXIS_W-1:0]      STEER_AXIS_RST = 8'd3;

  // Full-scale steer value is 2^15 - 1; the divider relies on that form.
  localparam int STEER_FULL_SCALE = 32767;
  localparam int STEER_SHIFT      = 15;
  localparam int DUTY_MAX         = 255;

endpackage

// ----- rtl/joystick_differential_drive_mixer_core.sv -----
// ----------------------------------------------------------------------------
// Joystick differential drive mixer core
// Turns joystick axis events into a direction flag and left/right motor
// duties, with a dead zone and exact integer steering mix.
// ----------------------------------------------------------------------------
// The core accepts one axis event per clock cycle and returns at most one
// result transaction per event, in event order. Events for the drive or
// steer axis update the held axis value in the cycle they are accepted; an
// event for any other axis, or a centered event while the held value is
// already zero, gives no result. An event passes through three registered
// stages: state update, the magnitude by steer multiply, and the divide by
// full scale with duty clamping. Each stage advances when the stage after it
// is empty or moving, so empty stages keep taking events while a finished
// result waits on out_stall, and the input stalls once all three stages hold
// an item and out_stall is high.
// Configuration writes are always ready and take effect on the next cycle.
module joystick_differential_drive_mixer_core #(
  parameter int DRIVE_SHIFT = 7
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Axis event channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [jddm_pkg::AXIS_W-1:0]           in_axis_number,
  input  logic signed [jddm_pkg::VALUE_W-1:0]   in_axis_value,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_forward,
  output logic [jddm_pkg::DUTY_W-1:0]           out_duty_left,
  output logic [jddm_pkg::DUTY_W-1:0]           out_duty_right,
  // Configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [jddm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jddm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import jddm_pkg::*;

  // Widths of the magnitude |drive| >> DRIVE_SHIFT, product, quotient, remainder and sums.
  localparam int MAG_W  = VALUE_W - DRIVE_SHIFT;
  localparam int PROD_W = MAG_W + VALUE_W;
  localparam int Q_W    = PROD_W - STEER_SHIFT;
  localparam int R_W    = STEER_SHIFT + 2;
  localparam int SUM_W  = MAG_W + 3;

  // Configuration registers
  logic [DEAD_ZONE_W-1:0] dead_zone_r;
  logic [AXIS_W-1:0]      drive_axis_id_r;
  logic [AXIS_W-1:0]      steer_axis_id_r;

  // Held axis values
  logic signed [VALUE_W-1:0] held_drive_r, held_drive_nxt;
  logic signed [VALUE_W-1:0] held_steer_r, held_steer_nxt;

  // Stage 1: snapshot of the mix inputs
  logic               s1_v_r, s1_v_nxt;
  logic               s1_fwd_r, s1_fwd_nxt;
  logic [MAG_W-1:0]   s1_mag_r, s1_mag_nxt;
  logic [VALUE_W-1:0] s1_steer_abs_r, s1_steer_abs_nxt;
  logic               s1_steer_neg_r, s1_steer_neg_nxt;

  // Stage 2: unsigned product
  logic               s2_v_r;
  logic               s2_fwd_r;
  logic [MAG_W-1:0]   s2_mag_r;
  logic               s2_neg_r;
  logic [PROD_W-1:0]  s2_prod_r, s2_prod_nxt;

  // Stage 3: result register
  logic               out_valid_r;
  logic               out_forward_r;
  logic [DUTY_W-1:0]  out_duty_left_r, out_duty_left_nxt;
  logic [DUTY_W-1:0]  out_duty_right_r, out_duty_right_nxt;

  // Per-stage advance
  logic s1_adv, s2_adv, s3_adv;
  logic in_accept;

  // Event decode
  logic signed [VALUE_W-1:0] dz_s;
  logic signed [VALUE_W-1:0] dz_neg_s;
  logic                      centered;
  logic                      hit_drive, hit_steer;
  logic signed [VALUE_W-1:0] held_sel;
  logic signed [VALUE_W-1:0] new_val;
  logic                      produce;
  logic [VALUE_W-1:0]        drive_abs;

  // Divide and mix
  logic [Q_W-1:0]            quot0, quot;
  logic [R_W-1:0]            rem0;
  logic signed [SUM_W-1:0]   mag_s, quot_s, sum_plus, sum_minus;

  // Clamp a signed sum to the duty range.
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [SUM_W-1:0] v);
    logic [DUTY_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > SUM_W'(DUTY_MAX)) begin
      res = DUTY_W'(DUTY_MAX);
    end else begin
      res = v[DUTY_W-1:0];
    end
    return res;
  endfunction

  // Handshake: each stage moves when the next one is empty or moving.
  assign s3_adv    = !out_valid_r || !out_stall;
  assign s2_adv    = !s2_v_r || s3_adv;
  assign s1_adv    = !s1_v_r || s2_adv;
  assign in_stall  = !s1_adv;
  assign in_accept = in_valid && s1_adv;
  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r     <= DEAD_ZONE_RST;
      drive_axis_id_r <= DRIVE_AXIS_RST;
      steer_axis_id_r <= STEER_AXIS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEAD_ZONE:  dead_zone_r     <= cfg_data[DEAD_ZONE_W-1:0];
        REG_DRIVE_AXIS: drive_axis_id_r <= cfg_data[AXIS_W-1:0];
        REG_STEER_AXIS: steer_axis_id_r <= cfg_data[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // Dead zone test, axis selection and held value update.
  always_comb begin
    dz_s      = signed'({1'b0, dead_zone_r});
    dz_neg_s  = -dz_s;
    centered  = (in_axis_value > dz_neg_s) && (in_axis_value < dz_s);
    hit_drive = (in_axis_number == drive_axis_id_r);
    hit_steer = !hit_drive && (in_axis_number == steer_axis_id_r);
    held_sel  = hit_drive ? held_drive_r : held_steer_r;
    new_val   = centered ? '0 : in_axis_value;
    produce   = (hit_drive || hit_steer) && !(centered && (held_sel == '0));

    held_drive_nxt = hit_drive ? new_val : held_drive_r;
    held_steer_nxt = hit_steer ? new_val : held_steer_r;

    // Absolute values; -32768 maps to 32768 in the unsigned result.
    drive_abs = held_drive_nxt[VALUE_W-1] ? (~held_drive_nxt + 1'b1) : held_drive_nxt;

    s1_v_nxt         = in_valid && produce;
    s1_fwd_nxt       = (held_drive_nxt > 0);
    s1_mag_nxt       = drive_abs[VALUE_W-1:DRIVE_SHIFT];
    s1_steer_neg_nxt = held_steer_nxt[VALUE_W-1];
    s1_steer_abs_nxt = held_steer_nxt[VALUE_W-1] ? (~held_steer_nxt + 1'b1)
                                                 : held_steer_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_drive_r <= '0;
      held_steer_r <= '0;
    end else if (in_accept && produce) begin
      held_drive_r <= held_drive_nxt;
      held_steer_r <= held_steer_nxt;
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_fwd_r       <= s1_fwd_nxt;
      s1_mag_r       <= s1_mag_nxt;
      s1_steer_abs_r <= s1_steer_abs_nxt;
      s1_steer_neg_r <= s1_steer_neg_nxt;
    end
  end

  // Stage 2: magnitude times steer magnitude.
  assign s2_prod_nxt = PROD_W'(s1_mag_r) * PROD_W'(s1_steer_abs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_fwd_r  <= s1_fwd_r;
      s2_mag_r  <= s1_mag_r;
      s2_neg_r  <= s1_steer_neg_r;
      s2_prod_r <= s2_prod_nxt;
    end
  end

  // Stage 3: divide by 2^15 - 1 and mix. With q0 = p >> 15 the remainder
  // p - q0 * (2^15 - 1) equals p[14:0] + q0, which stays below twice the
  // divisor, so one compare fixes the quotient.
  always_comb begin
    quot0     = s2_prod_r[PROD_W-1:STEER_SHIFT];
    rem0      = R_W'(s2_prod_r[STEER_SHIFT-1:0]) + R_W'(quot0);
    quot      = quot0 + Q_W'(rem0 >= R_W'(STEER_FULL_SCALE));
    mag_s     = signed'(SUM_W'(s2_mag_r));
    quot_s    = signed'(SUM_W'(quot));
    sum_plus  = mag_s + quot_s;
    sum_minus = mag_s - quot_s;
    // A negative steer swaps which side gets the offset.
    out_duty_left_nxt  = clamp_duty(s2_neg_r ? sum_minus : sum_plus);
    out_duty_right_nxt = clamp_duty(s2_neg_r ? sum_plus : sum_minus);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_adv) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      out_forward_r    <= s2_fwd_r;
      out_duty_left_r  <= out_duty_left_nxt;
      out_duty_right_r <= out_duty_right_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_forward    = out_forward_r;
  assign out_duty_left  = out_duty_left_r;
  assign out_duty_right = out_duty_right_r;

`ifndef SYNTHESIS
  // An accepted event for an unknown axis never enters the pipeline.
  a_ignore_other_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !hit_drive && !hit_steer) |=> !s1_v_r)
    else $error("event for an unmapped axis produced a pipeline entry");

  // The input stalls only when every stage holds an item.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && s1_v_r && s2_v_r))
    else $error("input stalled while the pipeline had a free stage");

  // The corrected quotient never exceeds 2^MAG_W.
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (SUM_W'(quot) <= (SUM_W'(1) << MAG_W)))
    else $error("steering quotient out of range");
`endif

endmodule
